// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Bodies drop out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property every clock, skipped while reset is held.
`define RVR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property every clock, reset included.
`define RVR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RVR_ASSERT(lbl, clk, rst_n, prop, msg)
`define RVR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/rvr_pkg.sv
`default_nettype none

package rvr_pkg;

  // Store geometry
  localparam int DEPTH      = 32;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Fixed field widths of the ports
  localparam int CMD_W   = 2;
  localparam int RANK_W  = 6;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int FILL_W  = 6;
  localparam int CMP_W   = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET     = 2'd0,
    CMD_REPLACE = 2'd1,
    CMD_INSERT  = 2'd2,
    CMD_REMOVE  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_GET,
    S_RD,
    S_WR,
    S_PUT,
    S_DONE
  } state_t;

  // Map a rank to its store slot; front + r stays below twice DEPTH.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                              input logic [CNT_W-1:0] r);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(front) + (CNT_W + 1)'(r);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return IDX_W'(sum);
  endfunction

endpackage

`default_nettype wire

// File: rtl/rvr_ram.sv
`default_nettype none

module rvr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/rank_vector_ring_core.sv
`default_nettype none

// Rank-indexed vector in a circular store of DEPTH entries. Each transfer on
// the in_ channel runs one command (get, replace, insert, remove) at a rank
// counted from the front element and yields one transfer on the out_ channel
// with the read value, a status, the element count and an empty flag. The
// block takes one command at a time; in_ready is high only while idle. A
// middle insert and a remove short of the last rank move the tail one
// element at a time, a read state then a write state, through the store's
// single read and write ports, with one shared slot adder forming every
// address but the write slot of a front insert, which steps the front back.
// Store contents after reset are undefined but never read before written;
// no clearing pass is needed and commands are taken right after reset.
module rank_vector_ring_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [5:0]  in_rank,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_read_value,
  output logic [1:0]       out_status,
  output logic [5:0]       out_fill_count,
  output logic             out_is_empty
);
  import rvr_pkg::*;

  `include "assert_macros.svh"

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        front_r, front_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  cmd_t                    cmd_r;
  logic [RANK_W-1:0]       rank_r;
  logic [DATA_WIDTH-1:0]   data_r;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [DATA_WIDTH-1:0]   rd_r, rd_nxt;
  status_t                 status_r, status_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]      out_read_value_r;
  logic [STAT_W-1:0]       out_status_r;
  logic [FILL_W-1:0]       out_fill_count_r;
  logic                    out_is_empty_r;
  logic                    out_load;

  // Shared slot adder and store port signals
  logic [CNT_W-1:0]        slot_r_in;
  logic [IDX_W-1:0]        slot_addr;
  logic [IDX_W-1:0]        front_dec;
  logic [CNT_W-1:0]        rank_c;
  logic                    rank_out;
  logic                    ram_we;
  logic                    waddr_front;
  logic [IDX_W-1:0]        ram_waddr;
  logic [DATA_WIDTH-1:0]   ram_wdata;
  logic [DATA_WIDTH-1:0]   ram_rdata;

  assign rank_c    = CNT_W'(rank_r);
  assign rank_out  = CMP_W'(rank_r) >= CMP_W'(count_r);
  assign front_dec = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - IDX_W'(1);
  assign slot_addr = slot_of(front_r, slot_r_in);
  assign in_ready  = (state_r == S_IDLE);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Write at the new front slot for a front insert, else at the adder's slot
  assign ram_waddr = waddr_front ? front_dec : slot_addr;

  rvr_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot_addr),
    .rdata (ram_rdata)
  );

  // Sequencer: next state, store access and bookkeeping
  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    rd_nxt      = rd_r;
    status_nxt  = status_r;
    slot_r_in   = rank_c;
    ram_we      = 1'b0;
    waddr_front = 1'b0;
    ram_wdata   = data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        rd_nxt     = '0;
        status_nxt = ST_OK;
        state_nxt  = S_DONE;
        if (cmd_r == CMD_INSERT) begin
          if (count_r >= CNT_W'(DEPTH)) begin
            status_nxt = ST_FULL;
          end else if (rank_r == '0) begin
            // Step the front back and place the value there
            front_nxt   = front_dec;
            ram_we      = 1'b1;
            waddr_front = 1'b1;
            count_nxt   = count_r + CNT_W'(1);
          end else if (rank_out) begin
            // Append after the last element
            slot_r_in = count_r;
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            idx_nxt   = count_r;
            state_nxt = S_RD;
          end
        end else if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (rank_out) begin
          status_nxt = ST_RANGE;
        end else begin
          unique case (cmd_r)
            CMD_GET: begin
              state_nxt = S_GET;
            end
            CMD_REPLACE: begin
              ram_we = 1'b1;
            end
            default: begin
              // Remove: shift the tail down unless the rank is the last one
              idx_nxt = rank_c;
              if ((CNT_W + 1)'(rank_c) + (CNT_W + 1)'(1) < (CNT_W + 1)'(count_r)) begin
                state_nxt = S_RD;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
          endcase
        end
      end
      S_GET: begin
        rd_nxt    = ram_rdata;
        state_nxt = S_DONE;
      end
      S_RD: begin
        // Fetch the neighbor that moves into slot idx
        if (cmd_r == CMD_INSERT) begin
          slot_r_in = idx_r - CNT_W'(1);
        end else begin
          slot_r_in = idx_r + CNT_W'(1);
        end
        state_nxt = S_WR;
      end
      S_WR: begin
        slot_r_in = idx_r;
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (cmd_r == CMD_INSERT) begin
          idx_nxt = idx_r - CNT_W'(1);
          if (idx_r - CNT_W'(1) == rank_c) begin
            state_nxt = S_PUT;
          end else begin
            state_nxt = S_RD;
          end
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
          if ((CNT_W + 1)'(idx_r) + (CNT_W + 1)'(2) >= (CNT_W + 1)'(count_r)) begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_PUT: begin
        // Drop the new value into the opened slot
        ram_we    = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result until the out_ transfer, then accept the next one
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= cmd_t'(in_cmd);
      rank_r <= in_rank;
      data_r <= DATA_WIDTH'(in_value);
    end
    idx_r    <= idx_nxt;
    rd_r     <= rd_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_read_value_r <= VALUE_W'(rd_r);
      out_status_r     <= status_r;
      out_fill_count_r <= FILL_W'(count_r);
      out_is_empty_r   <= (count_r == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_count_r;
  assign out_is_empty   = out_is_empty_r;

  `RVR_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(DEPTH), "count above store depth")
  `RVR_ASSERT(a_result_src, clk, rst_n, (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == S_DONE), "result raised outside done state")
  `RVR_ASSERT(a_count_step, clk, rst_n, (count_r != $past(count_r)) |-> ($past(state_r == S_DEC) || $past(state_r == S_WR) || $past(state_r == S_PUT)), "count changed outside an update step")
  `RVR_ASSERT(a_front_step, clk, rst_n, (front_r != $past(front_r)) |-> ($past(state_r == S_DEC) && $past(cmd_r == CMD_INSERT)), "front moved outside a front insert")

endmodule

`default_nettype wire

// File: dv/rank_vector_ring_core_test.sv
`timescale 1ns / 100ps

module rank_vector_ring_core_test;
  import rvr_pkg::*;

  localparam int RANDOM_CMDS = 550;
  localparam int DRAIN_WAIT  = 2 * DEPTH + 16;

  typedef struct {
    cmd_t        cmd;
    logic [5:0]  rank;
    logic [31:0] value;
  } ring_cmd_t;

  typedef struct {
    logic [31:0] read_value;
    status_t     status;
    logic [5:0]  fill_count;
    logic        is_empty;
  } ring_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = CMD_GET;
  logic [5:0]  in_rank = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_read_value;
  logic [1:0]  out_status;
  logic [5:0]  out_fill_count;
  logic        out_is_empty;

  rank_vector_ring_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_rank        (in_rank),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_fill_count (out_fill_count),
    .out_is_empty   (out_is_empty)
  );

  always #1 clk = ~clk;

  // Commands waiting to be driven, and results still owed by the block
  ring_cmd_t    pending_cmds[$];
  ring_result_t owed_results[$];
  int           cmds_total = 0;
  int           cmds_taken = 0;
  int           mismatches = 0;
  logic         in_done = 1'b0;

  // Shadow copy of the circular store
  logic [31:0] ring_mem[DEPTH];
  int          ring_front = 0;
  int          ring_count = 0;

  function automatic int ring_slot(input int r);
    return (ring_front + r) % DEPTH;
  endfunction

  // Run one command on the shadow store and return the result it yields.
  function automatic ring_result_t apply_ring_cmd(input cmd_t cmd, input logic [5:0] rank,
                                                  input logic [31:0] value);
    ring_result_t res;
    int r;
    int k;
    r = int'(rank);
    res.read_value = '0;
    res.status = ST_OK;
    if (cmd == CMD_INSERT) begin
      if (ring_count >= DEPTH) begin
        res.status = ST_FULL;
      end else if (r == 0) begin
        ring_front = (ring_front + DEPTH - 1) % DEPTH;
        ring_mem[ring_front] = value;
        ring_count++;
      end else if (r >= ring_count) begin
        ring_mem[ring_slot(ring_count)] = value;
        ring_count++;
      end else begin
        // open a hole at rank r by shifting the tail up
        for (k = ring_count; k > r; k--) begin
          ring_mem[ring_slot(k)] = ring_mem[ring_slot(k - 1)];
        end
        ring_mem[ring_slot(r)] = value;
        ring_count++;
      end
    end else if (ring_count == 0) begin
      res.status = ST_EMPTY;
    end else if (r >= ring_count) begin
      res.status = ST_RANGE;
    end else if (cmd == CMD_GET) begin
      res.read_value = ring_mem[ring_slot(r)];
    end else if (cmd == CMD_REPLACE) begin
      ring_mem[ring_slot(r)] = value;
    end else begin
      // close the gap at rank r by shifting the tail down
      for (k = r; k + 1 < ring_count; k++) begin
        ring_mem[ring_slot(k)] = ring_mem[ring_slot(k + 1)];
      end
      ring_count--;
    end
    res.fill_count = 6'(ring_count);
    res.is_empty = (ring_count == 0);
    return res;
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    $display("%0t: %s expected %0h got %0h", $time, field, want, got);
    mismatches++;
  endtask

  // Track input transfers into the shadow store and check output transfers
  always @(posedge clk) begin : check_results
    ring_result_t want;
    in_done <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        owed_results.push_back(apply_ring_cmd(cmd_t'(in_cmd), in_rank, in_value));
        cmds_taken++;
      end
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, status %0d count %0d",
                   $time, out_status, out_fill_count);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          if (out_read_value !== want.read_value)
            note_mismatch("read_value", want.read_value, out_read_value);
          if (out_status !== want.status)
            note_mismatch("status", 32'(want.status), 32'(out_status));
          if (out_fill_count !== want.fill_count)
            note_mismatch("fill_count", 32'(want.fill_count), 32'(out_fill_count));
          if (out_is_empty !== want.is_empty)
            note_mismatch("is_empty", 32'(want.is_empty), 32'(out_is_empty));
        end
      end
    end
  end

  // Drive commands in bursts separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin : drive_cmds
    ring_cmd_t item;
    if (rst_n && (!in_valid || in_done)) begin
      if (gap_left > 0 || pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        item = pending_cmds.pop_front();
        in_cmd   <= item.cmd;
        in_rank  <= item.rank;
        in_value <= item.value;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Pace the result side: segments of steady, light or heavy stalling,
  // plus two long hold-offs that back the block up into its input
  int rx_cycle = 0;
  int rx_seg_left = 0;
  int rx_seg_mode = 0;
  int rx_hold_left = 0;

  always @(negedge clk) begin : pace_results
    if (rst_n) begin
      rx_cycle++;
      if (rx_cycle == 1500 || rx_cycle == 12000) rx_hold_left = 300;
      if (rx_seg_left == 0) begin
        rx_seg_left = $urandom_range(16, 96);
        rx_seg_mode = $urandom_range(0, 2);
      end else begin
        rx_seg_left--;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_seg_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 4) < 2);
        endcase
      end
    end
  end

  // Command generation; gen_count follows the element count so ranks
  // land mostly on live positions
  int gen_count = 0;

  task automatic queue_cmd(input cmd_t cmd, input logic [5:0] rank, input logic [31:0] value);
    ring_cmd_t item;
    item.cmd = cmd;
    item.rank = rank;
    item.value = value;
    pending_cmds.push_back(item);
    cmds_total++;
    if (cmd == CMD_INSERT && gen_count < DEPTH) gen_count++;
    else if (cmd == CMD_REMOVE && gen_count > 0 && int'(rank) < gen_count) gen_count--;
  endtask

  initial begin : run_test
    int phase_left;
    int phase_mode;
    int w;
    int pick;
    cmd_t c;
    logic [5:0] r;
    logic [31:0] v;

    // Directed: empty store, front/append/middle inserts, range edges, removes
    queue_cmd(CMD_GET, 6'd0, 32'h0);
    queue_cmd(CMD_REPLACE, 6'd0, 32'hdead_beef);
    queue_cmd(CMD_REMOVE, 6'd0, 32'h0);
    queue_cmd(CMD_INSERT, 6'd0, 32'h0000_0000);
    queue_cmd(CMD_INSERT, 6'd63, 32'hffff_ffff);
    queue_cmd(CMD_INSERT, 6'd32, 32'ha5a5_a5a5);
    queue_cmd(CMD_INSERT, 6'd1, 32'h1234_5678);
    queue_cmd(CMD_GET, 6'd0, 32'h0);
    queue_cmd(CMD_GET, 6'd1, 32'h0);
    queue_cmd(CMD_GET, 6'd2, 32'h0);
    queue_cmd(CMD_GET, 6'd3, 32'hffff_ffff);
    queue_cmd(CMD_GET, 6'd4, 32'h0);
    queue_cmd(CMD_GET, 6'd63, 32'h0);
    queue_cmd(CMD_REPLACE, 6'd3, 32'hffff_ffff);
    queue_cmd(CMD_REPLACE, 6'd4, 32'h5555_5555);
    queue_cmd(CMD_REMOVE, 6'd4, 32'h0);
    queue_cmd(CMD_REMOVE, 6'd1, 32'h0);
    queue_cmd(CMD_REMOVE, 6'd2, 32'h0);
    queue_cmd(CMD_GET, 6'd0, 32'h0);
    queue_cmd(CMD_GET, 6'd1, 32'h0);
    queue_cmd(CMD_REMOVE, 6'd0, 32'h0);
    queue_cmd(CMD_REMOVE, 6'd0, 32'h0);
    queue_cmd(CMD_INSERT, 6'd5, 32'h8000_0001);
    queue_cmd(CMD_GET, 6'd0, 32'h0);

    // Random: alternate fill, drain and mixed phases so the store swings
    // between empty and full
    phase_left = 0;
    phase_mode = 0;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 90);
        phase_mode = (n == 0) ? 0 : $urandom_range(0, 2);
      end
      phase_left--;
      w = $urandom_range(0, 99);
      case (phase_mode)
        0: c = (w < 60) ? CMD_INSERT : (w < 75) ? CMD_GET : (w < 85) ? CMD_REPLACE : CMD_REMOVE;
        1: c = (w < 55) ? CMD_REMOVE : (w < 70) ? CMD_INSERT : (w < 85) ? CMD_GET : CMD_REPLACE;
        default: c = cmd_t'(w % 4);
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        if (c == CMD_INSERT) r = 6'($urandom_range(0, gen_count));
        else r = (gen_count > 0) ? 6'($urandom_range(0, gen_count - 1)) : 6'd0;
      end else if (pick == 7) begin
        r = 6'(gen_count);
      end else if (pick == 8) begin
        r = 6'd0;
      end else begin
        r = 6'($urandom_range(0, 63));
      end
      pick = $urandom_range(0, 9);
      v = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffff_ffff : 32'($urandom);
      queue_cmd(c, r, v);
    end

    // Hold reset, then release it on a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every command to transfer and every result to come back
    while (cmds_taken != cmds_total) @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #1_000_000;
    $display("%0t: timeout, %0d of %0d commands taken, %0d results owed",
             $time, cmds_taken, cmds_total, owed_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: rank_vector_ring_core.f
+incdir+rtl
rtl/rvr_pkg.sv
rtl/rvr_ram.sv
rtl/rank_vector_ring_core.sv
dv/rank_vector_ring_core_test.sv
